@@ rtl/core/rolling_pearson_correlation_unit_defines.svh @@
// Assertion macros for the rolling Pearson correlation unit.
`ifndef ROLLING_PEARSON_CORRELATION_UNIT_DEFINES_SVH
`define ROLLING_PEARSON_CORRELATION_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RPC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RPC_ASSERT_NOW(lbl, ante, cons)
`define RPC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/core/rpc_pkg.sv @@
// Shared constants and types of the rolling Pearson correlation unit.
package rpc_pkg;
  localparam int SAMPLE_W   = 16;
  localparam int WIN_MAX    = 256;
  localparam int SLOT_W     = $clog2(WIN_MAX);
  localparam int WLEN_W     = 9;
  localparam int WLEN_RESET = 20;
  localparam int SUM1_W     = 24;
  localparam int SUM2_W     = 40;
  localparam int OPND_W     = 48;
  localparam int LIMB_W     = 24;
  localparam int PROD_W     = 2 * LIMB_W + 2;
  localparam int ACC_W      = 96;
  localparam int SQ_W       = 94;
  localparam int QUO_W      = 31;
  localparam int ROOT_W     = 16;
  localparam int CORR_W     = 16;

  typedef struct packed {
    logic                     start;
    logic                     load;
    logic                     neg;
    logic                     a_wide;
    logic                     b_wide;
    logic signed [OPND_W-1:0] a;
    logic signed [OPND_W-1:0] b;
    logic signed [OPND_W-1:0] init;
  } mac_req_t;

  typedef struct packed {
    logic            start;
    logic [SQ_W-1:0] den;
    logic [SQ_W-1:0] sq;
  } root_req_t;
endpackage

@@ rtl/core/rpc_in_if.sv @@
// Sample pair request channel.
interface rpc_in_if;
  import rpc_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] x_sample;
  logic signed [SAMPLE_W-1:0] y_sample;
  modport source (output valid, output x_sample, output y_sample, input ready);
  modport sink (input valid, input x_sample, input y_sample, output ready);
endinterface

@@ rtl/core/rpc_out_if.sv @@
// Correlation result request channel.
interface rpc_out_if;
  import rpc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [CORR_W-1:0] correlation;
  logic                     flat;
  modport source (output valid, output correlation, output flat, input ready);
  modport sink (input valid, input correlation, input flat, output ready);
endinterface

@@ rtl/core/rpc_cfg_if.sv @@
// Window length configuration write channel.
interface rpc_cfg_if;
  import rpc_pkg::*;
  logic              valid;
  logic              ready;
  logic [WLEN_W-1:0] window_length;
  modport source (output valid, output window_length, input ready);
  modport sink (input valid, input window_length, output ready);
endinterface

@@ rtl/core/rpc_ram.sv @@
// Generic single-port-write, registered-read RAM.
module rpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

@@ rtl/core/rpc_mac.sv @@
// Shared multiply-accumulate unit: one 25x25 limb product per cycle.
module rpc_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rpc_pkg::mac_req_t                   req_i,
  output logic                                busy_o,
  output logic signed [rpc_pkg::ACC_W-1:0]    acc_o
);
  import rpc_pkg::*;

  logic                     busy_q;
  logic signed [OPND_W-1:0] a_q, b_q;
  logic                     aw_q, bw_q, neg_q;
  logic [1:0]               sel_q, sel_d;
  logic                     last;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [LIMB_W:0]   limb_a, limb_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  ext, shifted, term;

  always_comb begin
    limb_a = sel_q[0] ? {a_q[OPND_W-1], a_q[OPND_W-1:LIMB_W]}
                      : (aw_q ? {1'b0, a_q[LIMB_W-1:0]} : a_q[LIMB_W:0]);
    limb_b = sel_q[1] ? {b_q[OPND_W-1], b_q[OPND_W-1:LIMB_W]}
                      : (bw_q ? {1'b0, b_q[LIMB_W-1:0]} : b_q[LIMB_W:0]);
    prod = limb_a * limb_b;
    ext  = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    case (sel_q)
      2'b00:        shifted = ext;
      2'b01, 2'b10: shifted = ext << LIMB_W;
      default:      shifted = ext << (2 * LIMB_W);
    endcase
    term = neg_q ? -shifted : shifted;
    last  = 1'b0;
    sel_d = sel_q;
    if (!sel_q[0] && aw_q) begin
      sel_d = {sel_q[1], 1'b1};
    end else if (!sel_q[1] && bw_q) begin
      sel_d = 2'b10;
    end else begin
      last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sel_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      sel_q  <= '0;
    end else if (busy_q) begin
      sel_q <= sel_d;
      if (last) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      aw_q  <= req_i.a_wide;
      bw_q  <= req_i.b_wide;
      neg_q <= req_i.neg;
      if (req_i.load) begin
        acc_q <= {{(ACC_W-OPND_W){req_i.init[OPND_W-1]}}, req_i.init};
      end
    end else if (busy_q) begin
      acc_q <= acc_q + term;
    end
  end

  assign busy_o = busy_q;
  assign acc_o  = acc_q;
endmodule

@@ rtl/core/rpc_root.sv @@
// Shift-subtract unit: restoring divide, then integer square root.
module rpc_root (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rpc_pkg::root_req_t          req_i,
  output logic                        done_o,
  output logic [rpc_pkg::ROOT_W-1:0]  root_o
);
  import rpc_pkg::*;

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_DIV  = 2'd1;
  localparam logic [1:0] P_SQRT = 2'd2;

  logic [1:0]       phase_q;
  logic [4:0]       cnt_q;
  logic             done_q;
  logic [SQ_W-1:0]  rem_q, den_q;
  logic             lsb_q;
  logic [QUO_W-1:0] quo_q;
  logic [31:0]      num_q, res_q, bit_q;
  logic [SQ_W:0]    shl;
  logic [ACC_W-1:0] sub_a, sub_b, diff;
  logic             ge;

  always_comb begin
    shl = {rem_q, (cnt_q == '0) ? lsb_q : 1'b0};
    if (phase_q == P_SQRT) begin
      sub_a = {{(ACC_W-32){1'b0}}, num_q};
      sub_b = {{(ACC_W-32){1'b0}}, res_q | bit_q};
    end else begin
      sub_a = {{(ACC_W-SQ_W-1){1'b0}}, shl};
      sub_b = {{(ACC_W-SQ_W){1'b0}}, den_q};
    end
    diff = sub_a - sub_b;
    ge   = !diff[ACC_W-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (phase_q)
        P_IDLE: begin
          if (req_i.start) begin
            phase_q <= P_DIV;
            cnt_q   <= '0;
          end
        end
        P_DIV: begin
          if (cnt_q == 5'(QUO_W - 1)) begin
            phase_q <= P_SQRT;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        P_SQRT: begin
          if (cnt_q == 5'd15) begin
            phase_q <= P_IDLE;
            done_q  <= 1'b1;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        default: phase_q <= P_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (phase_q)
      P_IDLE: begin
        if (req_i.start) begin
          den_q <= req_i.den;
          rem_q <= {1'b0, req_i.sq[SQ_W-1:1]};
          lsb_q <= req_i.sq[0];
        end
      end
      P_DIV: begin
        rem_q <= ge ? diff[SQ_W-1:0] : shl[SQ_W-1:0];
        quo_q <= {quo_q[QUO_W-2:0], ge};
        if (cnt_q == 5'(QUO_W - 1)) begin
          num_q <= {1'b0, quo_q[QUO_W-2:0], ge};
          res_q <= '0;
          bit_q <= 32'h4000_0000;
        end
      end
      P_SQRT: begin
        if (ge) begin
          num_q <= diff[31:0];
          res_q <= (res_q >> 1) | bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign root_o = res_q[ROOT_W-1:0];
endmodule

@@ rtl/core/rolling_pearson_correlation_unit.sv @@
// Top level of the rolling Pearson correlation unit (ring, sums, sequencer).
// A flat result skips the divide/square-root unit; pairs taken before the window fills give no result.
// A new pair is taken only once the last is through; the pace is set by the shared 25x25
// multiply-accumulate and the 47 steps of the divide/square-root unit.
// A finished result waits in the output register while the next item is taken.
// Reset: window length 20, sums and counters cleared; ring contents are not cleared.
`include "rolling_pearson_correlation_unit_defines.svh"
module rolling_pearson_correlation_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  rpc_in_if.sink     sample_i,
  rpc_out_if.source  result_o,
  rpc_cfg_if.sink    cfg_i
);
  import rpc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_ROOT = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  localparam logic [3:0] OP_XX_ADD = 4'd0;
  localparam logic [3:0] OP_XX_SUB = 4'd1;
  localparam logic [3:0] OP_YY_ADD = 4'd2;
  localparam logic [3:0] OP_YY_SUB = 4'd3;
  localparam logic [3:0] OP_XY_ADD = 4'd4;
  localparam logic [3:0] OP_XY_SUB = 4'd5;
  localparam logic [3:0] OP_XD_N   = 4'd6;
  localparam logic [3:0] OP_XD_SQ  = 4'd7;
  localparam logic [3:0] OP_YD_N   = 4'd8;
  localparam logic [3:0] OP_YD_SQ  = 4'd9;
  localparam logic [3:0] OP_NUM_N  = 4'd10;
  localparam logic [3:0] OP_NUM_SQ = 4'd11;
  localparam logic [3:0] OP_DEN    = 4'd12;
  localparam logic [3:0] OP_MAG2   = 4'd13;

  logic [2:0]                 state_q;
  logic [3:0]                 op_q;
  logic                       issued_q, emit_q;
  logic [WLEN_W-1:0]          wlen_q, eff_w;
  logic [SLOT_W-1:0]          slot_q;
  logic [WLEN_W-1:0]          pairs_q, slot_nx;
  logic signed [SAMPLE_W-1:0] x_q, y_q, ox_q, oy_q, ox, oy;
  logic signed [SUM1_W-1:0]   sum_x_q, sum_y_q;
  logic signed [SUM2_W-1:0]   sum_xx_q, sum_yy_q, sum_xy_q;
  logic signed [OPND_W-1:0]   xd_q, yd_q, num_q, mag, n_ext;
  logic [SQ_W-1:0]            den_q;
  logic                       full_old;
  logic                       in_acc, cfg_acc, mac_busy, mac_done, root_done;
  logic [2*SAMPLE_W-1:0]      rdata;
  logic [ROOT_W-1:0]          root;
  logic [ROOT_W:0]            k_sum;
  logic signed [CORR_W-1:0]   k;
  logic                       out_vld_q, out_flat_q, res_flat_q;
  logic                       out_load;
  logic signed [CORR_W-1:0]   out_corr_q, res_corr_q;
  mac_req_t                   mac_req;
  root_req_t                  root_req;
  logic signed [ACC_W-1:0]    acc;

  assign sample_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready    = (state_q == S_IDLE);
  assign in_acc         = sample_i.valid && sample_i.ready;
  assign cfg_acc        = cfg_i.valid && cfg_i.ready;

  always_comb begin
    if (wlen_q == '0) begin
      eff_w = WLEN_W'(1);
    end else if (wlen_q > WLEN_W'(WIN_MAX)) begin
      eff_w = WLEN_W'(WIN_MAX);
    end else begin
      eff_w = wlen_q;
    end
  end

  assign full_old = (pairs_q >= eff_w);
  assign slot_nx  = {1'b0, slot_q} + WLEN_W'(1);
  assign ox       = full_old ? rdata[2*SAMPLE_W-1:SAMPLE_W] : '0;
  assign oy       = full_old ? rdata[SAMPLE_W-1:0] : '0;
  assign n_ext    = {{(OPND_W-WLEN_W){1'b0}}, eff_w};
  assign mag      = num_q[OPND_W-1] ? -num_q : num_q;
  assign mac_done = (state_q == S_MUL) && issued_q && !mac_busy;
  assign out_load = (state_q == S_FIN) && (!out_vld_q || result_o.ready);

  rpc_ram #(
    .WIDTH (2 * SAMPLE_W),
    .DEPTH (WIN_MAX)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (state_q == S_LOAD),
    .waddr_i (slot_q),
    .wdata_i ({x_q, y_q}),
    .re_i    (in_acc),
    .raddr_i (slot_q),
    .rdata_o (rdata)
  );

  always_comb begin
    mac_req = '0;
    if ((state_q == S_MUL) && !issued_q && !mac_busy) begin
      mac_req.start = 1'b1;
      case (op_q)
        OP_XX_ADD: begin
          mac_req.load = 1'b1;
          mac_req.init = {{(OPND_W-SUM2_W){sum_xx_q[SUM2_W-1]}}, sum_xx_q};
          mac_req.a    = {{(OPND_W-SAMPLE_W){x_q[SAMPLE_W-1]}}, x_q};
          mac_req.b    = {{(OPND_W-SAMPLE_W){x_q[SAMPLE_W-1]}}, x_q};
        end
        OP_XX_SUB: begin
          mac_req.neg = 1'b1;
          mac_req.a   = {{(OPND_W-SAMPLE_W){ox_q[SAMPLE_W-1]}}, ox_q};
          mac_req.b   = {{(OPND_W-SAMPLE_W){ox_q[SAMPLE_W-1]}}, ox_q};
        end
        OP_YY_ADD: begin
          mac_req.load = 1'b1;
          mac_req.init = {{(OPND_W-SUM2_W){sum_yy_q[SUM2_W-1]}}, sum_yy_q};
          mac_req.a    = {{(OPND_W-SAMPLE_W){y_q[SAMPLE_W-1]}}, y_q};
          mac_req.b    = {{(OPND_W-SAMPLE_W){y_q[SAMPLE_W-1]}}, y_q};
        end
        OP_YY_SUB: begin
          mac_req.neg = 1'b1;
          mac_req.a   = {{(OPND_W-SAMPLE_W){oy_q[SAMPLE_W-1]}}, oy_q};
          mac_req.b   = {{(OPND_W-SAMPLE_W){oy_q[SAMPLE_W-1]}}, oy_q};
        end
        OP_XY_ADD: begin
          mac_req.load = 1'b1;
          mac_req.init = {{(OPND_W-SUM2_W){sum_xy_q[SUM2_W-1]}}, sum_xy_q};
          mac_req.a    = {{(OPND_W-SAMPLE_W){x_q[SAMPLE_W-1]}}, x_q};
          mac_req.b    = {{(OPND_W-SAMPLE_W){y_q[SAMPLE_W-1]}}, y_q};
        end
        OP_XY_SUB: begin
          mac_req.neg = 1'b1;
          mac_req.a   = {{(OPND_W-SAMPLE_W){ox_q[SAMPLE_W-1]}}, ox_q};
          mac_req.b   = {{(OPND_W-SAMPLE_W){oy_q[SAMPLE_W-1]}}, oy_q};
        end
        OP_XD_N: begin
          mac_req.load   = 1'b1;
          mac_req.b_wide = 1'b1;
          mac_req.a      = n_ext;
          mac_req.b      = {{(OPND_W-SUM2_W){sum_xx_q[SUM2_W-1]}}, sum_xx_q};
        end
        OP_XD_SQ: begin
          mac_req.neg = 1'b1;
          mac_req.a   = {{(OPND_W-SUM1_W){sum_x_q[SUM1_W-1]}}, sum_x_q};
          mac_req.b   = {{(OPND_W-SUM1_W){sum_x_q[SUM1_W-1]}}, sum_x_q};
        end
        OP_YD_N: begin
          mac_req.load   = 1'b1;
          mac_req.b_wide = 1'b1;
          mac_req.a      = n_ext;
          mac_req.b      = {{(OPND_W-SUM2_W){sum_yy_q[SUM2_W-1]}}, sum_yy_q};
        end
        OP_YD_SQ: begin
          mac_req.neg = 1'b1;
          mac_req.a   = {{(OPND_W-SUM1_W){sum_y_q[SUM1_W-1]}}, sum_y_q};
          mac_req.b   = {{(OPND_W-SUM1_W){sum_y_q[SUM1_W-1]}}, sum_y_q};
        end
        OP_NUM_N: begin
          mac_req.load   = 1'b1;
          mac_req.b_wide = 1'b1;
          mac_req.a      = n_ext;
          mac_req.b      = {{(OPND_W-SUM2_W){sum_xy_q[SUM2_W-1]}}, sum_xy_q};
        end
        OP_NUM_SQ: begin
          mac_req.neg = 1'b1;
          mac_req.a   = {{(OPND_W-SUM1_W){sum_x_q[SUM1_W-1]}}, sum_x_q};
          mac_req.b   = {{(OPND_W-SUM1_W){sum_y_q[SUM1_W-1]}}, sum_y_q};
        end
        OP_DEN: begin
          mac_req.load   = 1'b1;
          mac_req.a_wide = 1'b1;
          mac_req.b_wide = 1'b1;
          mac_req.a      = xd_q;
          mac_req.b      = yd_q;
        end
        OP_MAG2: begin
          mac_req.load   = 1'b1;
          mac_req.a_wide = 1'b1;
          mac_req.b_wide = 1'b1;
          mac_req.a      = mag;
          mac_req.b      = mag;
        end
        default: mac_req.start = 1'b0;
      endcase
    end
  end

  rpc_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .busy_o (mac_busy),
    .acc_o  (acc)
  );

  always_comb begin
    root_req       = '0;
    root_req.start = mac_done && (op_q == OP_MAG2);
    root_req.den   = den_q;
    root_req.sq    = acc[SQ_W-1:0];
  end

  rpc_root u_root (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (root_req),
    .done_o (root_done),
    .root_o (root)
  );

  assign k_sum = {1'b0, root} + (ROOT_W+1)'(1);
  assign k     = k_sum[ROOT_W:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      op_q       <= '0;
      issued_q   <= 1'b0;
      emit_q     <= 1'b0;
      wlen_q     <= WLEN_W'(WLEN_RESET);
      slot_q     <= '0;
      pairs_q    <= '0;
      sum_x_q    <= '0;
      sum_y_q    <= '0;
      sum_xx_q   <= '0;
      sum_yy_q   <= '0;
      sum_xy_q   <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (result_o.valid && result_o.ready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cfg_acc) begin
            wlen_q   <= cfg_i.window_length;
            slot_q   <= '0;
            pairs_q  <= '0;
            sum_x_q  <= '0;
            sum_y_q  <= '0;
            sum_xx_q <= '0;
            sum_yy_q <= '0;
            sum_xy_q <= '0;
          end
          if (in_acc) begin
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          sum_x_q  <= sum_x_q + {{(SUM1_W-SAMPLE_W){x_q[SAMPLE_W-1]}}, x_q}
                              - {{(SUM1_W-SAMPLE_W){ox[SAMPLE_W-1]}}, ox};
          sum_y_q  <= sum_y_q + {{(SUM1_W-SAMPLE_W){y_q[SAMPLE_W-1]}}, y_q}
                              - {{(SUM1_W-SAMPLE_W){oy[SAMPLE_W-1]}}, oy};
          if (!full_old) begin
            pairs_q <= pairs_q + WLEN_W'(1);
          end
          emit_q   <= full_old || (pairs_q + WLEN_W'(1) >= eff_w);
          slot_q   <= (slot_nx >= eff_w) ? '0 : slot_nx[SLOT_W-1:0];
          op_q     <= OP_XX_ADD;
          issued_q <= 1'b0;
          state_q  <= S_MUL;
        end
        S_MUL: begin
          if (mac_req.start) begin
            issued_q <= 1'b1;
          end
          if (mac_done) begin
            issued_q <= 1'b0;
            op_q     <= op_q + 4'd1;
            case (op_q)
              OP_XX_SUB: sum_xx_q <= acc[SUM2_W-1:0];
              OP_YY_SUB: sum_yy_q <= acc[SUM2_W-1:0];
              OP_XY_SUB: begin
                sum_xy_q <= acc[SUM2_W-1:0];
                if (!emit_q) begin
                  state_q <= S_IDLE;
                end
              end
              OP_NUM_SQ: begin
                if (xd_q[OPND_W-1] || xd_q == '0 || yd_q[OPND_W-1] || yd_q == '0) begin
                  state_q <= S_FIN;
                end
              end
              OP_MAG2:   state_q <= S_ROOT;
              default: ;
            endcase
          end
        end
        S_ROOT: begin
          if (root_done) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q <= sample_i.x_sample;
      y_q <= sample_i.y_sample;
    end
    if (state_q == S_LOAD) begin
      ox_q <= ox;
      oy_q <= oy;
    end
    if (mac_done) begin
      case (op_q)
        OP_XD_SQ:  xd_q  <= acc[OPND_W-1:0];
        OP_YD_SQ:  yd_q  <= acc[OPND_W-1:0];
        OP_NUM_SQ: begin
          num_q      <= acc[OPND_W-1:0];
          res_corr_q <= '0;
          res_flat_q <= 1'b1;
        end
        OP_DEN:    den_q <= acc[SQ_W-1:0];
        default: ;
      endcase
    end
    if ((state_q == S_ROOT) && root_done) begin
      res_corr_q <= num_q[OPND_W-1] ? -k : k;
      res_flat_q <= 1'b0;
    end
    if (out_load) begin
      out_corr_q <= res_corr_q;
      out_flat_q <= res_flat_q;
    end
  end

  assign result_o.valid       = out_vld_q;
  assign result_o.correlation = out_corr_q;
  assign result_o.flat        = out_flat_q;

  `RPC_ASSERT_NEXT(a_accept_loads, in_acc, state_q == S_LOAD)
  `RPC_ASSERT_NOW(a_flat_is_zero, out_vld_q && out_flat_q, out_corr_q == '0)
  `RPC_ASSERT_NOW(a_corr_range, out_vld_q, out_corr_q <= 16'sd16384 && out_corr_q >= -16'sd16384)
  `RPC_ASSERT_NOW(a_pairs_bound, state_q == S_IDLE, pairs_q <= eff_w)
endmodule

@@ test/rpc_tb_pkg.sv @@
// Scoreboard class for the rolling Pearson correlation unit testbench.
`timescale 1ns / 1ps
package rpc_tb_pkg;
  import rpc_pkg::*;

  typedef struct packed {
    logic signed [CORR_W-1:0] correlation;
    logic                     flat;
  } corr_result_t;

  class corr_scoreboard;
    logic signed [SAMPLE_W-1:0] x_hist[WIN_MAX];
    logic signed [SAMPLE_W-1:0] y_hist[WIN_MAX];
    int unsigned slot;
    int unsigned filled;
    int unsigned win;
    longint sx, sy, sxx, syy, sxy;
    corr_result_t pending[$];
    int unsigned errors;

    function new();
      errors = 0;
      set_window(WLEN_RESET);
    endfunction

    function void set_window(int unsigned w);
      win = (w < 1) ? 1 : ((w > WIN_MAX) ? WIN_MAX : w);
      slot = 0;
      filled = 0;
      sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
    endfunction

    // r*16384 rounded half away from zero: largest k with (2k-1)^2*xd*yd <= num^2*2^30
    function void note_pair(logic signed [SAMPLE_W-1:0] xs, logic signed [SAMPLE_W-1:0] ys);
      longint x, y, ox, oy, n, xd, yd, num;
      logic [255:0] rhs, lhs, t;
      longint unsigned mag, lo, hi, k;
      corr_result_t r;
      x = xs; y = ys;
      if (filled >= win) begin
        ox = x_hist[slot]; oy = y_hist[slot];
        sx -= ox; sy -= oy; sxx -= ox * ox; syy -= oy * oy; sxy -= ox * oy;
      end else begin
        filled++;
      end
      x_hist[slot] = xs; y_hist[slot] = ys;
      sx += x; sy += y; sxx += x * x; syy += y * y; sxy += x * y;
      slot = (slot + 1 >= win) ? 0 : slot + 1;
      if (filled < win) return;
      n = win;
      xd = n * sxx - sx * sx;
      yd = n * syy - sy * sy;
      num = n * sxy - sx * sy;
      if (xd <= 0 || yd <= 0) begin
        r.correlation = 0;
        r.flat = 1'b1;
      end else begin
        mag = (num < 0) ? -num : num;
        rhs = (256'(mag) * 256'(mag)) << 30;
        lo = 0; hi = 16384;
        while (lo < hi) begin
          k = (lo + hi + 1) / 2;
          t = 256'(2 * k - 1);
          lhs = t * t * 256'(xd) * 256'(yd);
          if (lhs <= rhs) lo = k;
          else hi = k - 1;
        end
        r.correlation = (num < 0) ? -$signed(16'(lo)) : $signed(16'(lo));
        r.flat = 1'b0;
      end
      pending.push_back(r);
    endfunction

    function void check_result(corr_result_t got);
      corr_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result corr=%0d flat=%0b", $time, got.correlation, got.flat);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.correlation !== exp_r.correlation) begin
        $display("%0t: correlation expected %0d actual %0d", $time, exp_r.correlation,
                 got.correlation);
        errors++;
      end
      if (got.flat !== exp_r.flat) begin
        $display("%0t: flat expected %0b actual %0b", $time, exp_r.flat, got.flat);
        errors++;
      end
    endfunction
  endclass
endpackage

@@ test/rolling_pearson_correlation_unit_tb.sv @@
// Testbench top: drives sample pairs and window writes, checks correlation results.
`timescale 1ns / 1ps
module rolling_pearson_correlation_unit_tb;
  import rpc_pkg::*;
  import rpc_tb_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  rpc_in_if  sample_if();
  rpc_out_if result_if();
  rpc_cfg_if cfg_if();

  corr_scoreboard board;
  bit calm;
  bit hold_off;
  int unsigned cycles;

  rolling_pearson_correlation_unit dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if.sink),
    .result_o (result_if.source),
    .cfg_i    (cfg_if.sink)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("rolling_pearson_correlation_unit: mismatch");
      $finish;
    end
  end

  // result receiver with random stalls and one long hold-off
  initial begin
    int unsigned gap;
    bit held;
    corr_result_t got;
    result_if.ready = 1'b0;
    held = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (result_if.valid && result_if.ready) begin
        got.correlation = result_if.correlation;
        got.flat = result_if.flat;
        board.check_result(got);
      end
      if (hold_off && !held) begin
        held = 1;
        result_if.ready <= 1'b0;
        repeat (3000) @(posedge clk_i);
      end else if (gap > 0) begin
        gap--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
        if (!calm && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 14);
      end
    end
  end

  task automatic send_pair(logic signed [SAMPLE_W-1:0] xs, logic signed [SAMPLE_W-1:0] ys);
    if (!calm && $urandom_range(0, 7) == 0) begin
      sample_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    sample_if.valid <= 1'b1;
    sample_if.x_sample <= xs;
    sample_if.y_sample <= ys;
    do @(posedge clk_i); while (!sample_if.ready);
    board.note_pair(xs, ys);
  endtask

  task automatic drain();
    sample_if.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_window(int unsigned w);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.window_length <= w[WLEN_W-1:0];
    do @(posedge clk_i); while (!cfg_if.ready);
    board.set_window(w);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 4))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return $signed(16'($urandom_range(0, 15)) - 16'd8);
      default: return $signed(16'($urandom));
    endcase
  endfunction

  initial begin
    int unsigned wins[7];
    int unsigned w;
    logic signed [SAMPLE_W-1:0] xs;
    sample_if.valid = 1'b0;
    sample_if.x_sample = '0;
    sample_if.y_sample = '0;
    cfg_if.valid = 1'b0;
    cfg_if.window_length = '0;
    wins = '{1, 2, 256, 3, 7, 33, 20};
    board = new();
    calm = 0;
    hold_off = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset window, extremes, flat and anti correlation
    for (int i = 0; i < 20; i++) send_pair(16'sh7fff, $signed(16'(i)));
    send_pair(16'sh8000, 16'sh8000);
    send_pair(16'sh8000, 16'sh7fff);
    send_pair(16'sh1234, -16'sh1234);
    write_window(2);
    send_pair(16'sh0005, 16'sh0005);
    send_pair(16'sh0005, 16'sh0007);
    send_pair(16'sh8000, 16'sh7fff);
    send_pair(16'sh7fff, 16'sh8000);

    // random phases, long hold-off during the second
    for (int ph = 0; ph < 7; ph++) begin
      w = wins[ph];
      write_window(w);
      if (ph == 1) hold_off = 1;
      if (ph == 6) calm = 1;
      for (int i = 0; i < ((w == 256) ? 400 : 130); i++) begin
        xs = rand_sample();
        if ($urandom_range(0, 2) == 0)
          send_pair(xs, ($urandom_range(0, 1) != 0) ? xs : -xs);
        else
          send_pair(xs, rand_sample());
      end
      if (ph == 3) drain();
    end
    drain();
    if (board.errors == 0)
      $display("rolling_pearson_correlation_unit: match");
    else
      $display("rolling_pearson_correlation_unit: mismatch");
    $finish;
  end
endmodule
